>>> hdl/uoa_pkg.sv
// Shared types, sizes and helpers for the unit owner allocator.
// Used by every module of the block; depends on nothing.
package uoa_pkg;

    localparam int NUM_UNITS    = 16;
    localparam int TASK_ID_BITS = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int UNIT_IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int UNIT_CNT_W = $clog2(NUM_UNITS + 1);
    localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int TID_EXT_W  = (TASK_ID_BITS > 16) ? TASK_ID_BITS : 16;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_LIST  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] task_id;
        logic [4:0]  units_requested;
    } req_t;

    typedef struct packed {
        logic [3:0] unit_index;
        logic       has_unit;
        logic       last;
        logic       shortage;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic cont;
        logic need_push;
        logic out_free;
    } ctl_sts_t;

    function automatic logic [TASK_ID_BITS-1:0] task_mask(input logic [15:0] id);
        logic [TID_EXT_W-1:0] wide;
        wide = TID_EXT_W'(id);
        return wide[TASK_ID_BITS-1:0];
    endfunction

endpackage

>>> hdl/uoa_ctrl.sv
// Sequencer for the unit owner allocator: load, scan one unit a cycle unless a finished word cannot leave, finish.
// Depends on uoa_pkg.
module uoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  uoa_pkg::ctl_sts_t sts,
    output uoa_pkg::ctl_cmd_t cmd
);

    uoa_pkg::state_t state_reg;
    uoa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uoa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uoa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = uoa_pkg::ST_SCAN;
                end
            end
            uoa_pkg::ST_SCAN:
            begin
                if (!sts.cont && sts.out_free)
                begin
                    state_next = uoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            uoa_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            uoa_pkg::ST_SCAN:
            begin
                // hold the scan while a finished word cannot leave
                cmd.step   = sts.cont && (!sts.need_push || sts.out_free);
                cmd.finish = !sts.cont && sts.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/uoa_datapath.sv
// Owner table, scan pointer, pending result and output register.
// Depends on uoa_pkg; driven by uoa_ctrl through command and status structs.
module uoa_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  uoa_pkg::req_t     req,
    input  uoa_pkg::ctl_cmd_t cmd,
    output uoa_pkg::ctl_sts_t sts,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output uoa_pkg::rsp_t     rsp
);

    logic [uoa_pkg::TASK_ID_BITS-1:0] owner_reg [uoa_pkg::NUM_UNITS];
    logic [uoa_pkg::TASK_ID_BITS-1:0] owner_next [uoa_pkg::NUM_UNITS];

    logic [uoa_pkg::TASK_ID_BITS-1:0] task_reg, task_next;
    logic [1:0]                       act_reg, act_next;
    logic [4:0]                       remain_reg, remain_next;
    logic [uoa_pkg::UNIT_CNT_W-1:0]   idx_reg, idx_next;
    logic [uoa_pkg::RES_CNT_W-1:0]    count_reg, count_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [3:0]                       pend_idx_reg, pend_idx_next;
    logic                             out_valid_reg, out_valid_next;
    uoa_pkg::rsp_t                    out_reg, out_next;

    logic [uoa_pkg::TASK_ID_BITS-1:0] in_task;
    logic                             in_ignore;
    logic [uoa_pkg::TASK_ID_BITS-1:0] cur_owner;
    logic [31:0]                      idx_wide;
    logic                             hit;
    logic                             is_alloc;
    logic                             short_flag;

    assign in_task   = uoa_pkg::task_mask(req.task_id);
    assign in_ignore = (in_task == '0) || (req.action > uoa_pkg::ACT_LIST);
    assign cur_owner = owner_reg[idx_reg[uoa_pkg::UNIT_IDX_W-1:0]];
    assign idx_wide  = 32'(idx_reg);
    assign is_alloc  = (act_reg == uoa_pkg::ACT_ALLOC);
    assign hit       = is_alloc ? (cur_owner == '0) : (cur_owner == task_reg);
    assign short_flag = is_alloc && (remain_reg != 5'd0);

    assign sts.cont = (idx_reg < uoa_pkg::UNIT_CNT_W'(uoa_pkg::NUM_UNITS))
                      && (!is_alloc || (remain_reg != 5'd0))
                      && (count_reg < uoa_pkg::RES_CNT_W'(uoa_pkg::MAX_RESULTS));
    assign sts.need_push = hit && pend_valid_reg && (act_reg != uoa_pkg::ACT_FREE);
    assign sts.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        owner_next      = owner_reg;
        task_next       = task_reg;
        act_next        = act_reg;
        remain_next     = remain_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_next        = out_reg;

        if (cmd.load)
        begin
            task_next       = in_task;
            // an ignored item scans nothing and finishes with no shortage
            act_next        = in_ignore ? uoa_pkg::ACT_FREE : req.action;
            remain_next     = req.units_requested;
            idx_next        = in_ignore ? uoa_pkg::UNIT_CNT_W'(uoa_pkg::NUM_UNITS) : '0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + 1'b1;
            if (hit)
            begin
                if (act_reg == uoa_pkg::ACT_FREE)
                begin
                    owner_next[idx_reg[uoa_pkg::UNIT_IDX_W-1:0]] = '0;
                end
                else
                begin
                    if (is_alloc)
                    begin
                        owner_next[idx_reg[uoa_pkg::UNIT_IDX_W-1:0]] = task_reg;
                        remain_next = remain_reg - 5'd1;
                    end
                    count_next      = count_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_wide[3:0];
                    if (pend_valid_reg)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.unit_index = pend_idx_reg;
                        out_next.has_unit   = 1'b1;
                        out_next.last       = 1'b0;
                        out_next.shortage   = 1'b0;
                    end
                end
            end
        end

        if (cmd.finish)
        begin
            out_valid_next      = 1'b1;
            out_next.unit_index = pend_valid_reg ? pend_idx_reg : 4'd0;
            out_next.has_unit   = pend_valid_reg;
            out_next.last       = 1'b1;
            out_next.shortage   = short_flag;
            pend_valid_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uoa_pkg::NUM_UNITS; i++)
            begin
                owner_reg[i] <= '0;
            end
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            act_reg        <= uoa_pkg::ACT_FREE;
        end
        else
        begin
            owner_reg      <= owner_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            act_reg        <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg     <= task_next;
        remain_reg   <= remain_next;
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

endmodule

>>> hdl/unit_owner_allocator_unit.sv
// Top level of the unit owner allocator: sequencer plus datapath.
// Depends on uoa_pkg, uoa_ctrl and uoa_datapath.
//
// First-fit owner table for NUM_UNITS compute units, one task id per unit,
// all free after reset. A request word allocates units to a task (lowest
// free index first, partial grant kept and flagged as shortage), frees every
// unit a task owns, or lists the units a task owns. Each request answers
// with one or more response words, the final one marked last; a request
// that yields no unit answers with a single word with has_unit low. A task
// id of zero or an unknown action is ignored and answers that way too.
// Sequence: the request is taken first, then the table is scanned one
// unit per cycle through a single read/write port of the owner table,
// and the final word is emitted last; an allocate stops scanning as soon
// as its request is met. A stall on the response side holds the scan
// whenever a finished word has nowhere to go. The request side is stalled
// from acceptance until the final word is handed to the output register.
module unit_owner_allocator_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  uoa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output uoa_pkg::rsp_t rsp
);

    // command and status between sequencer and datapath
    uoa_pkg::ctl_cmd_t cmd;
    uoa_pkg::ctl_sts_t sts;

    uoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table, scan state, one pending word to settle the last mark, output reg
    uoa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

>>> hdl/uoa_checker.sv
// Port-level checks for unit_owner_allocator_unit, bound to the top level.
// Depends on uoa_pkg.
module uoa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input uoa_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input uoa_pkg::rsp_t rsp
);

    // hold a stalled request word
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request word changed while stalled");

    // hold a stalled response word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // an empty answer is always the final word of its request
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.has_unit |-> rsp.last && (rsp.unit_index == 4'd0))
        else $error("empty answer not final or carries an index");

    // shortage shows only on the final word
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.shortage |-> rsp.last)
        else $error("shortage on a non-final word");

    // a new request is never taken right after a word that is not final
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp.last |-> req_stall)
        else $error("request taken while an answer is still in progress");

endmodule

bind unit_owner_allocator_unit uoa_checker u_uoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
